// ===== design/all_pairs_nearest_neighbour_assert.svh =====
// Assertion macros used by the nearest-neighbour engine.
`ifndef ALL_PAIRS_NEAREST_NEIGHBOUR_ASSERT_SVH
`define ALL_PAIRS_NEAREST_NEIGHBOUR_ASSERT_SVH
// Implication checked every clock outside reset.
`define APNN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define APNN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/apnn_pkg.sv =====
// Shared types and constants for the nearest-neighbour block.
`default_nettype none
package apnn_pkg;
  localparam int IdW   = 31;
  localparam int CoW   = 24;
  localparam int DistW = 25;
  localparam int SqW   = 50;
  localparam int TotW  = 31;
  localparam logic [DistW-1:0] DistSat = '1;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [CoW-1:0] x;
    logic [CoW-1:0] y;
    logic           last;
  } point_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [CoW-1:0]   x;
    logic [CoW-1:0]   y;
    logic [IdW-1:0]   nb_id;
    logic             found;
    logic [DistW-1:0] near_dist;
    logic [DistW-1:0] mean;
    logic             dropped;
    logic             last;
  } result_t;
endpackage
`default_nettype wire

// ===== design/apnn_queue.sv =====
// Two-entry queue between the loader front end and the search engine.
`default_nettype none
module apnn_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire apnn_pkg::point_t wr_data,
  output logic                 full,
  output logic                 empty,
  input  wire logic            rd_en,
  output apnn_pkg::point_t     rd_data
);
  import apnn_pkg::*;
  point_t mem_r [2];
  logic   wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

// ===== design/apnn_engine.sv =====
// Back end: point store, pairwise distance scan, square root, mean, result register.
`default_nettype none
`include "all_pairs_nearest_neighbour_assert.svh"
module apnn_engine #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire apnn_pkg::point_t q_data,
  output logic                  q_rd,
  output logic                  res_valid,
  output apnn_pkg::result_t     res,
  input  wire logic             res_stall
);
  import apnn_pkg::*;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001, S_RDI  = 7'b0000010, S_SCAN = 7'b0000100,
    S_SQRT = 7'b0001000, S_DIV  = 7'b0010000, S_OUT  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CoW-1:0] mx_r [MAX_POINTS];
  logic [CoW-1:0] my_r [MAX_POINTS];
  logic [IdW-1:0] mid_r [MAX_POINTS];

  logic [CW-1:0]  cnt_r;
  logic           ovf_r;
  logic [TotW-1:0] tot_r;
  logic [AW-1:0]  i_r;
  logic [CW-1:0]  j_r;       // read address of the scan
  logic [AW-1:0]  rd_addr;
  logic [CoW-1:0] rx_r, ry_r;
  logic [IdW-1:0] rid_r;
  logic [CoW-1:0] ix_r, iy_r;
  logic [IdW-1:0] iid_r;
  // Pipeline: read (j) -> diff -> square -> compare.
  logic           v1_r, v2_r, v3_r;
  logic [AW-1:0]  j1_r;
  logic [IdW-1:0] id2_r;
  logic [CoW:0]   dx_r, dy_r;
  logic [SqW-1:0] sq_r;
  logic [IdW-1:0] id3b_r;
  logic           found_r;
  logic [SqW-1:0] best_r;
  logic [IdW-1:0] bid_r;
  // Square root and division.
  logic [SqW-1:0] rem_r;
  logic [DistW:0] root_r;
  logic [5:0]     step_r;
  logic [DistW-1:0] dist_r;
  logic [TotW-1:0] drem_r, quo_r;

  logic ld_last;
  assign q_rd = (state_r == S_LOAD) && !q_empty;
  assign ld_last = q_rd && q_data.last;

  always_ff @(posedge clk) begin
    if (q_rd && (cnt_r < CW'(MAX_POINTS))) begin
      mx_r[cnt_r[AW-1:0]]  <= q_data.x;
      my_r[cnt_r[AW-1:0]]  <= q_data.y;
      mid_r[cnt_r[AW-1:0]] <= q_data.id;
    end
  end

  assign rd_addr = (state_r == S_RDI) ? i_r : j_r[AW-1:0];
  always_ff @(posedge clk) begin
    rx_r  <= mx_r[rd_addr];
    ry_r  <= my_r[rd_addr];
    rid_r <= mid_r[rd_addr];
  end

  logic [CoW:0] dxa, dya;
  logic [SqW-1:0] sq_nxt;
  always_comb begin
    dxa = dx_r[CoW] ? -dx_r : dx_r;
    dya = dy_r[CoW] ? -dy_r : dy_r;
    sq_nxt = SqW'(dxa) * SqW'(dxa) + SqW'(dya) * SqW'(dya);
  end

  // Restoring square root, two radicand bits per step.
  logic [SqW-1:0] trial;
  logic [DistW:0] root_sh;
  logic [SqW-1:0] rem_sh;
  always_comb begin
    root_sh = root_r << 1;
    trial   = (SqW'(rem_r) << 2) | SqW'(best_r >> (2 * (6'd24 - step_r)) & 2'b11);
    rem_sh  = trial;
  end
  logic [SqW-1:0] cand;
  assign cand = SqW'({root_r, 2'b01});

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = cnt_r - CW'(1);
  logic scan_done;
  assign scan_done = (j_r == cnt_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (ld_last) state_nxt = S_RDI;
      S_RDI:  state_nxt = S_SCAN;
      S_SCAN: if (scan_done && !v1_r && !v2_r && !v3_r) state_nxt = S_SQRT;
      S_SQRT: if (step_r == 6'd24) state_nxt = (i_r == cnt_m1[AW-1:0]) ? S_DIV : S_OUT;
      S_DIV:  if (step_r == 6'(TotW - 1)) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_WAIT;
      S_WAIT: if (!res_stall) state_nxt = res.last ? S_LOAD : S_RDI;
      default: state_nxt = S_LOAD;
    endcase
  end

  logic [TotW-1:0] dshift;
  assign dshift = {drem_r[TotW-2:0], tot_r[TotW-1-step_r[4:0]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; tot_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; res_valid <= 1'b0; i_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_rd) begin
        if (cnt_r < CW'(MAX_POINTS)) cnt_r <= cnt_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      v1_r <= (state_r == S_SCAN) && !scan_done;
      v2_r <= v1_r && (j1_r != i_r);
      v3_r <= v2_r;
      unique case (state_r)
        S_RDI: begin j_r <= '0; found_r <= 1'b0; bid_r <= '0; best_r <= '0; end
        S_SCAN: begin
          // The i point is read in S_RDI and lands in the read register on the first scan cycle.
          if (j_r == '0 && !v1_r && !v2_r && !v3_r) begin
            ix_r <= rx_r; iy_r <= ry_r; iid_r <= rid_r;
          end
          if (!scan_done) j_r <= j_r + CW'(1);
          if (v3_r && (!found_r || sq_r < best_r)) begin
            found_r <= 1'b1; best_r <= sq_r; bid_r <= id3b_r;
          end
          rem_r <= '0; root_r <= '0; step_r <= '0;
        end
        S_SQRT: begin
          if (rem_sh >= cand) begin
            rem_r <= rem_sh - cand; root_r <= root_sh | (DistW+1)'(1);
          end else begin
            rem_r <= rem_sh; root_r <= root_sh;
          end
          if (step_r == 6'd24) begin
            step_r <= '0; drem_r <= '0; quo_r <= '0;
            dist_r <= found_r ? ((rem_sh >= cand) ? DistW'(root_sh | 1) : DistW'(root_sh))
                              : DistSat;
            tot_r <= tot_r + TotW'(found_r ? ((rem_sh >= cand) ? DistW'(root_sh | 1)
                              : DistW'(root_sh)) : DistSat);
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_DIV: begin
          step_r <= step_r + 6'd1;
          if (dshift >= TotW'(cnt_r)) begin
            drem_r <= dshift - TotW'(cnt_r); quo_r <= {quo_r[TotW-2:0], 1'b1};
          end else begin
            drem_r <= dshift; quo_r <= {quo_r[TotW-2:0], 1'b0};
          end
        end
        S_OUT: begin
          res_valid     <= 1'b1;
          res.id        <= iid_r; res.x <= ix_r; res.y <= iy_r;
          res.nb_id     <= bid_r; res.found <= found_r; res.near_dist <= dist_r;
          res.dropped   <= ovf_r;
          res.last      <= (i_r == cnt_m1[AW-1:0]);
          res.mean      <= (i_r == cnt_m1[AW-1:0]) ? DistW'(quo_r) : '0;
        end
        S_WAIT: if (!res_stall) begin
          res_valid <= 1'b0;
          if (res.last) begin
            i_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; tot_r <= '0;
          end else i_r <= i_r + AW'(1);
        end
        default: ;
      endcase
      j1_r <= j_r[AW-1:0];
      dx_r <= {ix_r[CoW-1], ix_r} - {rx_r[CoW-1], rx_r};
      dy_r <= {iy_r[CoW-1], iy_r} - {ry_r[CoW-1], ry_r};
      id2_r <= rid_r;
      sq_r <= sq_nxt; id3b_r <= id2_r;
    end
  end

  `APNN_ASSERT_IMP(a_out_hold, clk, rst_n, res_valid && res_stall, state_r == S_WAIT,
    "result register dropped while stalled")
  `APNN_ASSERT_IMP(a_no_load_busy, clk, rst_n, q_rd, state_r == S_LOAD,
    "queue read outside load phase")
  `APNN_ASSERT_NXT(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_POINTS),
    "point count beyond capacity")
  `APNN_ASSERT_IMP(a_scan_idle, clk, rst_n, state_r == S_SQRT, !v1_r && !v2_r && !v3_r,
    "distance pipe busy during square root")
endmodule
`default_nettype wire

// ===== design/all_pairs_nearest_neighbour.sv =====
// Top level of the brute-force all-pairs nearest-neighbour block.
// Usage: points stream in on the in_ channel (valid/stall), one beat per point;
// a beat with in_final_point set closes the set and starts the search.
// Points beyond MAX_POINTS are dropped and flagged on every result.
// The front end is a two-entry queue, so in_stall only rises while the
// search engine is busy and the queue is full.
// For each stored point the engine reads every other point through one
// pipelined distance unit, then runs a 25-step square root; the last
// point adds a 31-step divide for the mean.
// Results leave on the out_ channel from one output register; while
// out_stall is high the result holds and the engine waits.
// Reset (synchronous, rst_n low) empties the queue and the point count;
// the point store itself is not cleared.
`default_nettype none
module all_pairs_nearest_neighbour #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] in_point_id,
  input  wire logic [23:0] in_coord_x,
  input  wire logic [23:0] in_coord_y,
  input  wire logic        in_final_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_id,
  output logic [23:0]      out_x,
  output logic [23:0]      out_y,
  output logic [30:0]      out_neighbour_id,
  output logic             out_neighbour_found,
  output logic [24:0]      out_nearest_distance,
  output logic [24:0]      out_mean_distance,
  output logic             out_dropped_points,
  output logic             out_final_result
);
  import apnn_pkg::*;
  point_t  wr_pt, rd_pt;
  result_t res;
  logic    q_full, q_empty, q_rd;

  assign in_stall = q_full;
  assign wr_pt = '{id: in_point_id, x: in_coord_x, y: in_coord_y, last: in_final_point};

  apnn_queue u_q (
    .clk, .rst_n, .wr_en(in_valid && !q_full), .wr_data(wr_pt),
    .full(q_full), .empty(q_empty), .rd_en(q_rd), .rd_data(rd_pt)
  );

  apnn_engine #(.MAX_POINTS(MAX_POINTS)) u_eng (
    .clk, .rst_n, .q_empty, .q_data(rd_pt), .q_rd,
    .res_valid(out_valid), .res, .res_stall(out_stall)
  );

  assign out_id               = res.id;
  assign out_x                = res.x;
  assign out_y                = res.y;
  assign out_neighbour_id     = res.nb_id;
  assign out_neighbour_found  = res.found;
  assign out_nearest_distance = res.near_dist;
  assign out_mean_distance    = res.mean;
  assign out_dropped_points   = res.dropped;
  assign out_final_result     = res.last;
endmodule
`default_nettype wire
